/* rtl/subb_pkg.sv */
// Shared types, constants and helpers of the SPI UART bridge buffer engine.
package subb_pkg;

	localparam int RX_DEPTH   = 255;
	localparam int TX_DEPTH   = 255;
	localparam int DROP_BLOCK = 16;
	localparam int MAX_RAW    = 6;

	localparam int RAW_FIELDS = 6;
	localparam int RAW_MAX    = (MAX_RAW < RAW_FIELDS) ? MAX_RAW : RAW_FIELDS;
	localparam int DROP       = (DROP_BLOCK < RX_DEPTH) ? DROP_BLOCK : RX_DEPTH;
	localparam int FRAME_LEN  = 5;

	localparam int RX_AW = $clog2(RX_DEPTH);
	localparam int RX_CW = $clog2(RX_DEPTH + 1);
	localparam int RX_SW = RX_CW + 1;
	localparam int TX_AW = $clog2(TX_DEPTH);
	localparam int TX_CW = $clog2(TX_DEPTH + 1);
	localparam int TX_SW = TX_CW + 1;
	localparam int WIN_W = TX_CW + 2;

	localparam logic [2:0] OP_TICK   = 3'd0;
	localparam logic [2:0] OP_FRAMED = 3'd1;
	localparam logic [2:0] OP_RAW    = 3'd2;
	localparam logic [2:0] OP_GET    = 3'd3;
	localparam logic [2:0] OP_CLR_RX = 3'd4;
	localparam logic [2:0] OP_CLR_TX = 3'd5;
	localparam logic [2:0] OP_ARM    = 3'd6;

	localparam logic [7:0] FRAME_B0 = 8'h05;
	localparam logic [7:0] FRAME_B1 = 8'h02;
	localparam logic [7:0] FRAME_B2 = 8'h01;
	localparam logic [7:0] FRAME_B3 = 8'h01;

	typedef struct packed {
		logic [2:0] operation;
		logic [2:0] raw_count;
		logic [7:0] raw_byte_0;
		logic [7:0] raw_byte_1;
		logic [7:0] raw_byte_2;
		logic [7:0] raw_byte_3;
		logic [7:0] raw_byte_4;
		logic [7:0] raw_byte_5;
		logic [1:0] capture_len;
	} subb_item_t;

	typedef struct packed {
		logic [7:0] spi_out;
		logic       accepted;
		logic [7:0] read_byte;
		logic       capture_valid;
		logic       capture_index;
		logic [7:0] capture_byte;
		logic       capture_done;
		logic [7:0] rx_available;
		logic [7:0] tx_pending;
	} subb_result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_WRITE,
		ST_DONE
	} subb_state_t;

	function automatic logic [7:0] sat8(input logic [15:0] v);
		return (v > 16'd255) ? 8'hFF : v[7:0];
	endfunction

	function automatic logic [7:0] frame_byte(input logic [2:0] k, input logic [7:0] c);
		logic [7:0] b;
		case (k)
			3'd0: b = FRAME_B0;
			3'd1: b = FRAME_B1;
			3'd2: b = FRAME_B2;
			3'd3: b = FRAME_B3;
			default: b = c;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] pick_byte(input subb_item_t it, input logic [2:0] k);
		logic [7:0] b;
		case (k)
			3'd0: b = it.raw_byte_0;
			3'd1: b = it.raw_byte_1;
			3'd2: b = it.raw_byte_2;
			3'd3: b = it.raw_byte_3;
			3'd4: b = it.raw_byte_4;
			3'd5: b = it.raw_byte_5;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

/* rtl/spi_uart_bridge_buffers.sv */
// Top level of the SPI UART bridge buffer engine: queues, capture window and result register.
// One operation is taken at a time and gives one result. A tick that sends a byte or a get char
// that finds one goes through execute, a synchronous memory read and the result load; other ticks
// and gets, clears, arming, unused codes and puts that do not fit go from execute to the result
// load; a put that fits writes its bytes one per cycle in between, since the transmit memory has
// a single write port (five for a framed char put, up to six for a raw put). Receive and transmit
// bytes live in two single-port-write memories with registered read data; a full receive FIFO
// drops its oldest block on the next received byte. The result load waits for a free output
// register; a finished result sits there while the next operation is taken in.
module spi_uart_bridge_buffers (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  subb_pkg::subb_item_t  item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output subb_pkg::subb_result_t result
);
	import subb_pkg::*;

	localparam logic signed [WIN_W-1:0] WIN_ZERO = '0;
	localparam logic signed [WIN_W-1:0] WIN_ONE  = WIN_W'(1);

	subb_state_t state_q, state_d;
	subb_item_t item_q;
	subb_result_t res_q, res_d;
	subb_result_t res_out;

	logic [RX_AW-1:0] rx_base_q, rx_base_d;
	logic [RX_CW-1:0] rx_fill_q, rx_fill_d;
	logic [RX_CW-1:0] rx_rd_q, rx_rd_d;
	logic [TX_CW-1:0] tx_fill_q, tx_fill_d;
	logic [TX_CW-1:0] tx_send_q, tx_send_d;
	logic cap_act_q, cap_act_d;
	logic signed [WIN_W-1:0] win_start_q, win_start_d;
	logic signed [WIN_W-1:0] win_stop_q, win_stop_d;
	logic [2:0] wr_cnt_q, wr_cnt_d;
	logic [2:0] wr_len_q, wr_len_d;

	logic [7:0] rx_mem [RX_DEPTH];
	logic [7:0] tx_mem [TX_DEPTH];
	logic [7:0] rx_rdata_q, tx_rdata_q;
	logic rx_we, rx_re, tx_we, tx_re;
	logic [RX_AW-1:0] rx_waddr, rx_raddr;
	logic [TX_AW-1:0] tx_waddr, tx_raddr;
	logic [7:0] rx_wdata, tx_wdata;
	logic load;

	logic [RX_AW-1:0] push_base;
	logic [RX_CW-1:0] push_fill, push_rd;
	logic [2:0] raw_n;
	logic [1:0] cap_len;
	logic signed [WIN_W-1:0] win_s, win_t, arm_stop, arm_start;

	function automatic logic [RX_AW-1:0] rx_add(input logic [RX_AW-1:0] base,
		input logic [RX_CW-1:0] off);
		logic [RX_SW-1:0] sum;
		sum = RX_SW'(base) + RX_SW'(off);
		if (sum >= RX_SW'(RX_DEPTH)) begin
			sum = sum - RX_SW'(RX_DEPTH);
		end
		return sum[RX_AW-1:0];
	endfunction

	always_comb begin
		state_d     = state_q;
		res_d       = res_q;
		rx_base_d   = rx_base_q;
		rx_fill_d   = rx_fill_q;
		rx_rd_d     = rx_rd_q;
		tx_fill_d   = tx_fill_q;
		tx_send_d   = tx_send_q;
		cap_act_d   = cap_act_q;
		win_start_d = win_start_q;
		win_stop_d  = win_stop_q;
		wr_cnt_d    = wr_cnt_q;
		wr_len_d    = wr_len_q;
		rx_we       = 1'b0;
		rx_re       = 1'b0;
		tx_we       = 1'b0;
		tx_re       = 1'b0;
		rx_waddr    = '0;
		rx_raddr    = '0;
		tx_waddr    = '0;
		tx_raddr    = '0;
		rx_wdata    = 8'h00;
		tx_wdata    = 8'h00;
		load        = 1'b0;
		push_base   = rx_base_q;
		push_fill   = rx_fill_q;
		push_rd     = rx_rd_q;
		raw_n       = '0;
		cap_len     = item_q.capture_len;
		win_s       = win_start_q - WIN_ONE;
		win_t       = win_stop_q - WIN_ONE;
		arm_stop    = signed'(WIN_W'(tx_fill_q - tx_send_q));
		arm_start   = WIN_ZERO;
		item_stall  = (state_q != ST_IDLE);

		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				res_d   = '0;
				state_d = ST_DONE;
				case (item_q.operation)
					OP_TICK: begin
						if (tx_send_q < tx_fill_q) begin
							tx_re    = 1'b1;
							tx_raddr = tx_send_q[TX_AW-1:0];
							state_d  = ST_READ;
							if (tx_send_q + TX_CW'(1) == tx_fill_q) begin
								tx_fill_d = '0;
								tx_send_d = '0;
							end else begin
								tx_send_d = tx_send_q + TX_CW'(1);
							end
						end
						if (cap_act_q) begin
							win_start_d = win_s;
							win_stop_d  = win_t;
							if (win_s <= WIN_ZERO && win_t >= WIN_ZERO) begin
								res_d.capture_valid = 1'b1;
								res_d.capture_index = win_s[0];
								res_d.capture_byte  = item_q.raw_byte_0;
							end
							if (win_t <= WIN_ZERO) begin
								cap_act_d          = 1'b0;
								res_d.capture_done = 1'b1;
							end
						end else if (item_q.raw_byte_0 != 8'h00) begin
							if (rx_fill_q >= RX_CW'(RX_DEPTH)) begin
								push_base = rx_add(rx_base_q, RX_CW'(DROP));
								push_fill = RX_CW'(RX_DEPTH - DROP);
								push_rd   = (rx_rd_q >= RX_CW'(DROP)) ?
									rx_rd_q - RX_CW'(DROP) : '0;
							end
							rx_we     = 1'b1;
							rx_waddr  = rx_add(push_base, push_fill);
							rx_wdata  = item_q.raw_byte_0;
							rx_base_d = push_base;
							rx_fill_d = push_fill + RX_CW'(1);
							rx_rd_d   = push_rd;
						end
					end
					OP_FRAMED: begin
						if (TX_SW'(tx_fill_q) + TX_SW'(FRAME_LEN) < TX_SW'(TX_DEPTH)) begin
							res_d.accepted = 1'b1;
							wr_cnt_d       = '0;
							wr_len_d       = 3'(FRAME_LEN);
							state_d        = ST_WRITE;
						end
					end
					OP_RAW: begin
						raw_n = (item_q.raw_count > 3'(RAW_MAX)) ? 3'(RAW_MAX) :
							item_q.raw_count;
						if (TX_CW'(raw_n) <= TX_CW'(TX_DEPTH) - tx_fill_q) begin
							res_d.accepted = 1'b1;
							if (raw_n != 3'd0) begin
								wr_cnt_d = '0;
								wr_len_d = raw_n;
								state_d  = ST_WRITE;
							end
						end
					end
					OP_GET: begin
						if (rx_rd_q < rx_fill_q) begin
							rx_re          = 1'b1;
							rx_raddr       = rx_add(rx_base_q, rx_rd_q);
							res_d.accepted = 1'b1;
							state_d        = ST_READ;
							if (rx_rd_q + RX_CW'(1) == rx_fill_q) begin
								rx_fill_d = '0;
								rx_rd_d   = '0;
							end else begin
								rx_rd_d = rx_rd_q + RX_CW'(1);
							end
						end
					end
					OP_CLR_RX: begin
						rx_fill_d = '0;
						rx_rd_d   = '0;
						rx_base_d = '0;
					end
					OP_CLR_TX: begin
						tx_fill_d = '0;
						tx_send_d = '0;
					end
					OP_ARM: begin
						if (item_q.capture_len == 2'd0) begin
							cap_len = 2'd1;
						end else if (item_q.capture_len == 2'd3) begin
							cap_len = 2'd2;
						end
						arm_start   = arm_stop - signed'(WIN_W'(cap_len)) + WIN_ONE;
						win_stop_d  = arm_stop;
						win_start_d = arm_start;
						if (arm_stop <= WIN_ZERO) begin
							cap_act_d          = 1'b0;
							res_d.capture_done = 1'b1;
						end else begin
							cap_act_d = 1'b1;
						end
					end
					default: ;
				endcase
			end
			ST_READ: begin
				state_d = ST_DONE;
				if (item_q.operation == OP_TICK) begin
					res_d.spi_out = tx_rdata_q;
				end else begin
					res_d.read_byte = rx_rdata_q;
				end
			end
			ST_WRITE: begin
				tx_we    = 1'b1;
				tx_waddr = TX_AW'(tx_fill_q + TX_CW'(wr_cnt_q));
				tx_wdata = (item_q.operation == OP_FRAMED) ?
					frame_byte(wr_cnt_q, item_q.raw_byte_0) : pick_byte(item_q, wr_cnt_q);
				wr_cnt_d = wr_cnt_q + 3'd1;
				if (wr_cnt_q == wr_len_q - 3'd1) begin
					tx_fill_d = tx_fill_q + TX_CW'(wr_len_q);
					state_d   = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!result_valid || !result_stall) begin
					load    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rx_base_q   <= '0;
			rx_fill_q   <= '0;
			rx_rd_q     <= '0;
			tx_fill_q   <= '0;
			tx_send_q   <= '0;
			cap_act_q   <= 1'b0;
			win_start_q <= '0;
			win_stop_q  <= '0;
			wr_cnt_q    <= '0;
			wr_len_q    <= '0;
		end else begin
			state_q     <= state_d;
			rx_base_q   <= rx_base_d;
			rx_fill_q   <= rx_fill_d;
			rx_rd_q     <= rx_rd_d;
			tx_fill_q   <= tx_fill_d;
			tx_send_q   <= tx_send_d;
			cap_act_q   <= cap_act_d;
			win_start_q <= win_start_d;
			win_stop_q  <= win_stop_d;
			wr_cnt_q    <= wr_cnt_d;
			wr_len_q    <= wr_len_d;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (state_q == ST_IDLE && item_valid) begin
			item_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (load) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_comb begin
		res_out              = res_q;
		res_out.rx_available = sat8(16'(rx_fill_q - rx_rd_q));
		res_out.tx_pending   = sat8(16'(tx_fill_q - tx_send_q));
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result <= res_out;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_we) begin
			rx_mem[rx_waddr] <= rx_wdata;
		end
		if (rx_re) begin
			rx_rdata_q <= rx_mem[rx_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (tx_we) begin
			tx_mem[tx_waddr] <= tx_wdata;
		end
		if (tx_re) begin
			tx_rdata_q <= tx_mem[tx_raddr];
		end
	end

	a_rx_order: assert property (@(posedge clk) disable iff (!arst_n)
		rx_rd_q <= rx_fill_q) else $error("rx read position beyond fill");

	a_tx_order: assert property (@(posedge clk) disable iff (!arst_n)
		tx_send_q <= tx_fill_q) else $error("tx send position beyond fill");

	a_rx_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		rx_fill_q <= RX_CW'(RX_DEPTH) && RX_CW'(rx_base_q) < RX_CW'(RX_DEPTH))
		else $error("rx fill or base out of range");

	a_read_hit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.read_byte != 8'h00 |-> result.accepted)
		else $error("read byte without accepted");

	a_write_op: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WRITE |-> item_q.operation == OP_FRAMED || item_q.operation == OP_RAW)
		else $error("tx write burst outside a put");

endmodule
